// ----- sv/wrf_pkg.sv -----
// ----------------------------------------------------------------------------
// wrf_pkg
// Shared widths, types and command codes of the waypoint route follower.
// ----------------------------------------------------------------------------
`default_nettype none

package wrf_pkg;

  // Field widths
  localparam int LAT_W      = 40;
  localparam int LON_W      = 41;
  localparam int ALT_W      = 32;
  localparam int DT_W       = 24;
  localparam int SPEED_W    = 44;
  localparam int TIME_W     = 40;
  localparam int POS_OUT_W  = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 44;

  typedef logic signed [LAT_W-1:0] lat_t;
  typedef logic signed [LON_W-1:0] lon_t;
  typedef logic signed [ALT_W-1:0] alt_t;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVEMENT = 2'd3;

  // Reset values of the throttle registers
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd1048576;
  localparam logic [31:0] MIN_MOVEMENT_RST = 32'd4295;

  // Squared distance below this is a waypoint closer than 1e-9 degree
  localparam logic [95:0] SKIP_D2 = 96'd19;

endpackage

`default_nettype wire

// ----- sv/wrf_if.sv -----
// ----------------------------------------------------------------------------
// wrf_in_if / wrf_out_if
// Valid/ready channels carrying command words and fix words.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrf_in_if;
  logic                               valid;
  logic                               ready;
  logic [wrf_pkg::MODE_W-1:0]         mode;
  logic                               route_start;
  logic signed [wrf_pkg::LAT_W-1:0]   latitude;
  logic signed [wrf_pkg::LON_W-1:0]   longitude;
  logic signed [wrf_pkg::ALT_W-1:0]   altitude;
  logic [wrf_pkg::DT_W-1:0]           delta_time;

  modport source (output valid, mode, route_start, latitude, longitude, altitude,
                  delta_time, input ready);
  modport sink   (input valid, mode, route_start, latitude, longitude, altitude,
                  delta_time, output ready);
endinterface

interface wrf_out_if;
  logic                               valid;
  logic                               ready;
  logic                               fix_emitted;
  logic signed [wrf_pkg::LON_W-1:0]   fix_longitude;
  logic signed [wrf_pkg::LAT_W-1:0]   fix_latitude;
  logic signed [wrf_pkg::ALT_W-1:0]   fix_altitude;
  logic [wrf_pkg::POS_OUT_W-1:0]      waypoint_position;
  logic                               route_finished;

  modport source (output valid, fix_emitted, fix_longitude, fix_latitude, fix_altitude,
                  waypoint_position, route_finished, input ready);
  modport sink   (input valid, fix_emitted, fix_longitude, fix_latitude, fix_altitude,
                  waypoint_position, route_finished, output ready);
endinterface

`default_nettype wire

// ----- sv/waypoint_route_follower.sv -----
// ----------------------------------------------------------------------------
// waypoint_route_follower
// Moves a position along a stored waypoint route at a set speed.
// ----------------------------------------------------------------------------
// Every command word gives one fix word. Load, set-location, unused-mode and
// non-moving tick words finish without leaving the idle state. A moving tick
// runs through one shared shift-add multiplier for the step, the squared
// distance and the squared step, and then snaps to or skips a waypoint. When
// it interpolates instead, a bit-serial square root, two more products and
// two restoring divisions follow. The route sits in one RAM of ROUTE_DEPTH
// entries, read one entry per moving tick. Only one word is in work at a
// time; a new word is taken once the previous fix word has left or is
// leaving the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_route_follower #(
  parameter int ROUTE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  wrf_in_if.sink                         in_ch,
  wrf_out_if.source                      out_ch
);
  import wrf_pkg::*;

  localparam int IW = $clog2(ROUTE_DEPTH);
  localparam int LW = $clog2(ROUTE_DEPTH + 1);
  localparam int RW = LAT_W + LON_W + ALT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_STEP = 4'd2;
  localparam logic [3:0] S_DX   = 4'd3;
  localparam logic [3:0] S_DY   = 4'd4;
  localparam logic [3:0] S_S2   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_MX   = 4'd8;
  localparam logic [3:0] S_VX   = 4'd9;
  localparam logic [3:0] S_MY   = 4'd10;
  localparam logic [3:0] S_VY   = 4'd11;
  localparam logic [3:0] S_THR  = 4'd12;

  localparam logic [6:0] MUL_LAST  = 7'd47;
  localparam logic [6:0] SQRT_LAST = 7'd47;
  localparam logic [6:0] DIV_LAST  = 7'd95;

  // Control state
  logic [3:0]        state_r, state_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              running_r;
  logic [SPEED_W-1:0] speed_r;
  logic [31:0]       min_int_r, min_mv_r;
  logic [LW-1:0]     len_r, len_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Position state
  lat_t cur_lat_r, cur_lat_nxt, last_lat_r, last_lat_nxt;
  lon_t cur_lon_r, cur_lon_nxt, last_lon_r, last_lon_nxt;
  alt_t cur_alt_r, cur_alt_nxt;

  // Datapath
  logic [DT_W-1:0]  dt_r, dt_nxt;
  lat_t             wp_lat_r, wp_lat_nxt;
  lon_t             wp_lon_r, wp_lon_nxt;
  alt_t             wp_alt_r, wp_alt_nxt;
  logic [40:0]      dx_r, dx_nxt;
  logic [41:0]      dy_r, dy_nxt;
  logic [47:0]      step_r, step_nxt;
  logic [95:0]      d2_r, d2_nxt, s2_r, s2_nxt;
  logic [47:0]      mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [95:0]      acc_r, acc_nxt;
  logic [95:0]      sh_r, sh_nxt;
  logic [51:0]      rem_r, rem_nxt;
  logic [47:0]      q_r, q_nxt, dist_r, dist_nxt;
  logic             noemit_r, noemit_nxt;

  // Output register
  logic              o_fix_r, o_fix_nxt, o_fin_r, o_fin_nxt;
  lat_t              o_lat_r, o_lat_nxt;
  lon_t              o_lon_r, o_lon_nxt;
  alt_t              o_alt_r, o_alt_nxt;
  logic [POS_OUT_W-1:0] o_pos_r, o_pos_nxt;

  // RAM ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  // Helpers
  logic          accept;
  logic [95:0]   acc_step;
  logic [51:0]   sq_rem, sq_trial, dv_rem, dv_dsr;
  logic          sq_ge, dv_ge;
  logic [47:0]   q_fin;
  logic [40:0]   mag_dx;
  logic [41:0]   mag_dy;
  logic [LW-1:0] len_base;
  logic [40:0]   since_sum;
  logic [40:0]   thr_dlat, thr_mlat;
  logic [41:0]   thr_dlon, thr_mlon;
  logic          thr_quiet;
  logic          out_load, out_fix;

  function automatic logic route_end(input logic [LW-1:0] len, input logic [IW-1:0] pos);
    route_end = (len == '0) || ((LW'(pos) + LW'(1)) >= len);
  endfunction

  wrf_ram #(.WIDTH(RW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Serial arithmetic steps
  assign acc_step = {acc_r[94:0], 1'b0} + (mul_b_r[47] ? {48'd0, mul_a_r} : 96'd0);
  assign sq_rem   = {rem_r[49:0], sh_r[95:94]};
  assign sq_trial = {2'b00, q_r, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;
  assign dv_rem   = {rem_r[50:0], sh_r[95]};
  assign dv_dsr   = {4'd0, dist_r};
  assign dv_ge    = dv_rem >= dv_dsr;
  assign q_fin    = {q_r[46:0], dv_ge};
  assign mag_dx   = dx_r[40] ? (41'd0 - dx_r) : dx_r;
  assign mag_dy   = dy_r[41] ? (42'd0 - dy_r) : dy_r;

  // Throttle test on the current position
  assign thr_dlat  = {cur_lat_r[LAT_W-1], cur_lat_r} - {last_lat_r[LAT_W-1], last_lat_r};
  assign thr_mlat  = thr_dlat[40] ? (41'd0 - thr_dlat) : thr_dlat;
  assign thr_dlon  = {cur_lon_r[LON_W-1], cur_lon_r} - {last_lon_r[LON_W-1], last_lon_r};
  assign thr_mlon  = thr_dlon[41] ? (42'd0 - thr_dlon) : thr_dlon;
  assign thr_quiet = (since_r < TIME_W'(min_int_r)) && (thr_mlat < 41'(min_mv_r))
                     && (thr_mlon < 42'(min_mv_r));

  assign len_base  = in_ch.route_start ? '0 : len_r;
  assign since_sum = {1'b0, since_r} + 41'(in_ch.delta_time);

  // Sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    since_nxt     = since_r;
    cur_lat_nxt   = cur_lat_r;
    cur_lon_nxt   = cur_lon_r;
    cur_alt_nxt   = cur_alt_r;
    last_lat_nxt  = last_lat_r;
    last_lon_nxt  = last_lon_r;
    dt_nxt        = dt_r;
    wp_lat_nxt    = wp_lat_r;
    wp_lon_nxt    = wp_lon_r;
    wp_alt_nxt    = wp_alt_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    step_nxt      = step_r;
    d2_nxt        = d2_r;
    s2_nxt        = s2_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dist_nxt      = dist_r;
    noemit_nxt    = noemit_r;
    ram_we        = 1'b0;
    ram_waddr     = IW'(len_base);
    ram_wdata     = {in_ch.altitude, in_ch.longitude, in_ch.latitude};
    ram_re        = 1'b0;
    ram_raddr     = pos_r + IW'(1);
    out_load      = 1'b0;
    out_fix       = 1'b0;

    // Multiplier runs in every product state
    if (state_r == S_STEP || state_r == S_DX || state_r == S_DY || state_r == S_S2 ||
        state_r == S_MX || state_r == S_MY) begin
      acc_nxt   = acc_step;
      mul_b_nxt = {mul_b_r[46:0], 1'b0};
      cnt_nxt   = cnt_r + 7'd1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_LOAD: begin
              pos_nxt = in_ch.route_start ? '0 : pos_r;
              len_nxt = len_base;
              if (len_base < LW'(ROUTE_DEPTH)) begin
                ram_we  = 1'b1;
                len_nxt = len_base + LW'(1);
              end
              out_load = 1'b1;
            end
            MODE_SET: begin
              cur_lat_nxt  = in_ch.latitude;
              cur_lon_nxt  = in_ch.longitude;
              cur_alt_nxt  = in_ch.altitude;
              last_lat_nxt = in_ch.latitude;
              last_lon_nxt = in_ch.longitude;
              since_nxt    = '0;
              out_load     = 1'b1;
              out_fix      = 1'b1;
            end
            MODE_TICK: begin
              since_nxt = since_sum[40] ? '1 : since_sum[TIME_W-1:0];
              if (!running_r || route_end(len_r, pos_r)) begin
                out_load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                dt_nxt    = in_ch.delta_time;
                state_nxt = S_RD;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        // Next waypoint arrives; start step = speed * dt
        wp_lat_nxt = ram_rdata[LAT_W-1:0];
        wp_lon_nxt = ram_rdata[LAT_W+LON_W-1:LAT_W];
        wp_alt_nxt = ram_rdata[RW-1:LAT_W+LON_W];
        dx_nxt     = {ram_rdata[LAT_W-1], ram_rdata[LAT_W-1:0]}
                     - {cur_lat_r[LAT_W-1], cur_lat_r};
        dy_nxt     = {ram_rdata[LAT_W+LON_W-1], ram_rdata[LAT_W+LON_W-1:LAT_W]}
                     - {cur_lon_r[LON_W-1], cur_lon_r};
        mul_a_nxt  = 48'(speed_r);
        mul_b_nxt  = 48'(dt_r);
        acc_nxt    = '0;
        cnt_nxt    = '0;
        noemit_nxt = 1'b0;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (cnt_r == MUL_LAST) begin
          step_nxt  = acc_step[67:20];
          mul_a_nxt = 48'(mag_dx);
          mul_b_nxt = 48'(mag_dx);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        if (cnt_r == MUL_LAST) begin
          d2_nxt    = acc_step;
          mul_a_nxt = 48'(mag_dy);
          mul_b_nxt = 48'(mag_dy);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DY;
        end
      end
      S_DY: begin
        if (cnt_r == MUL_LAST) begin
          d2_nxt    = d2_r + acc_step;
          mul_a_nxt = step_r;
          mul_b_nxt = step_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_S2;
        end
      end
      S_S2: begin
        if (cnt_r == MUL_LAST) begin
          s2_nxt    = acc_step;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (d2_r < SKIP_D2) begin
          // waypoint too close: pass it, no fix
          pos_nxt    = pos_r + IW'(1);
          noemit_nxt = 1'b1;
          state_nxt  = S_THR;
        end else if (d2_r <= s2_r) begin
          // step reaches the waypoint: snap
          cur_lat_nxt = wp_lat_r;
          cur_lon_nxt = wp_lon_r;
          cur_alt_nxt = wp_alt_r;
          pos_nxt     = pos_r + IW'(1);
          state_nxt   = S_THR;
        end else begin
          sh_nxt    = d2_r;
          rem_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        rem_nxt = sq_ge ? (sq_rem - sq_trial) : sq_rem;
        q_nxt   = {q_r[46:0], sq_ge};
        sh_nxt  = {sh_r[93:0], 2'b00};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == SQRT_LAST) begin
          dist_nxt  = {q_r[46:0], sq_ge};
          mul_a_nxt = 48'(mag_dx);
          mul_b_nxt = step_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MX;
        end
      end
      S_MX, S_MY: begin
        if (cnt_r == MUL_LAST) begin
          sh_nxt    = acc_step;
          rem_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = (state_r == S_MX) ? S_VX : S_VY;
        end
      end
      S_VX, S_VY: begin
        // one quotient bit per cycle
        rem_nxt = dv_ge ? (dv_rem - dv_dsr) : dv_rem;
        q_nxt   = q_fin;
        sh_nxt  = {sh_r[94:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          if (state_r == S_VX) begin
            cur_lat_nxt = LAT_W'({cur_lat_r[LAT_W-1], cur_lat_r}
                          + (dx_r[40] ? (41'd0 - 41'(q_fin)) : 41'(q_fin)));
            mul_a_nxt   = 48'(mag_dy);
            mul_b_nxt   = step_r;
            acc_nxt     = '0;
            cnt_nxt     = '0;
            state_nxt   = S_MY;
          end else begin
            cur_lon_nxt = LON_W'({cur_lon_r[LON_W-1], cur_lon_r}
                          + (dy_r[41] ? (42'd0 - 42'(q_fin)) : 42'(q_fin)));
            state_nxt   = S_THR;
          end
        end
      end
      S_THR: begin
        out_load = 1'b1;
        if (!noemit_r && !thr_quiet) begin
          out_fix      = 1'b1;
          last_lat_nxt = cur_lat_r;
          last_lon_nxt = cur_lon_r;
          since_nxt    = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_fix_nxt     = o_fix_r;
    o_lat_nxt     = o_lat_r;
    o_lon_nxt     = o_lon_r;
    o_alt_nxt     = o_alt_r;
    o_pos_nxt     = o_pos_r;
    o_fin_nxt     = o_fin_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      o_fix_nxt     = out_fix;
      o_lat_nxt     = cur_lat_nxt;
      o_lon_nxt     = cur_lon_nxt;
      o_alt_nxt     = cur_alt_nxt;
      o_pos_nxt     = POS_OUT_W'(pos_nxt);
      o_fin_nxt     = route_end(len_nxt, pos_nxt);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.fix_emitted       = o_fix_r;
  assign out_ch.fix_longitude     = o_lon_r;
  assign out_ch.fix_latitude      = o_lat_r;
  assign out_ch.fix_altitude      = o_alt_r;
  assign out_ch.waypoint_position = o_pos_r;
  assign out_ch.route_finished    = o_fin_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      running_r   <= 1'b0;
      speed_r     <= '0;
      min_int_r   <= MIN_INTERVAL_RST;
      min_mv_r    <= MIN_MOVEMENT_RST;
      len_r       <= '0;
      pos_r       <= '0;
      since_r     <= '1;
      cur_lat_r   <= '0;
      cur_lon_r   <= '0;
      cur_alt_r   <= '0;
      last_lat_r  <= '0;
      last_lon_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      since_r     <= since_nxt;
      cur_lat_r   <= cur_lat_nxt;
      cur_lon_r   <= cur_lon_nxt;
      cur_alt_r   <= cur_alt_nxt;
      last_lat_r  <= last_lat_nxt;
      last_lon_r  <= last_lon_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RUNNING:      running_r <= cfg_wdata[0];
          REG_SPEED:        speed_r   <= cfg_wdata[SPEED_W-1:0];
          REG_MIN_INTERVAL: min_int_r <= cfg_wdata[31:0];
          REG_MIN_MOVEMENT: min_mv_r  <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dt_r     <= dt_nxt;
    wp_lat_r <= wp_lat_nxt;
    wp_lon_r <= wp_lon_nxt;
    wp_alt_r <= wp_alt_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    step_r   <= step_nxt;
    d2_r     <= d2_nxt;
    s2_r     <= s2_nxt;
    mul_a_r  <= mul_a_nxt;
    mul_b_r  <= mul_b_nxt;
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    dist_r   <= dist_nxt;
    noemit_r <= noemit_nxt;
    o_fix_r  <= o_fix_nxt;
    o_lat_r  <= o_lat_nxt;
    o_lon_r  <= o_lon_nxt;
    o_alt_r  <= o_alt_nxt;
    o_pos_r  <= o_pos_nxt;
    o_fin_r  <= o_fin_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/wrf_ram.sv -----
// ----------------------------------------------------------------------------
// wrf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/wrf_checker.sv -----
// ----------------------------------------------------------------------------
// wrf_checker
// Port-level checks of the waypoint route follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wrf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [wrf_pkg::MODE_W-1:0]        in_mode,
  input logic signed [wrf_pkg::LAT_W-1:0]  in_lat,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_fix,
  input logic signed [wrf_pkg::LAT_W-1:0]  out_lat
);
  import wrf_pkg::*;

  // A pending fix word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lat))
    else $error("fix word changed while stalled");

  // A word is only taken when the output register frees up
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("command taken with output register full");

  // Set location reports the new position at once
  a_set_fix: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_SET
    |=> out_valid && out_fix && out_lat == $past(in_lat))
    else $error("set location did not emit its fix");

  // Loading a waypoint never emits a fix
  a_load_nofix: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_LOAD |=> out_valid && !out_fix)
    else $error("waypoint load gave a wrong word");

endmodule

bind waypoint_route_follower wrf_checker u_wrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .in_lat    (in_ch.latitude),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_fix   (out_ch.fix_emitted),
  .out_lat   (out_ch.fix_latitude)
);

`default_nettype wire
